### src/pbr_pkg.sv
// Shared types, widths and helpers for the path bounds rescale core.
package pbr_pkg;

	localparam int VW = 32;          // coordinate width, Q16.16
	localparam int TW = 31;          // tolerance width
	localparam int IN_TW = 72;       // input tdata width
	localparam int OUT_TW = 40;      // output tdata width
	localparam int IDXW = 6;         // point_index width
	localparam int AW_MD = 33;       // multiplicand / divisor width
	localparam int BW_MD = 34;       // multiplier / quotient width

	// Configuration register indexes
	localparam logic [1:0] REG_SOURCE_MIN = 2'd0;
	localparam logic [1:0] REG_SOURCE_MAX = 2'd1;
	localparam logic [1:0] REG_TOLERANCE  = 2'd2;

	// Point flags as stored
	typedef struct packed {
		logic locked;
		logic raw_present;
		logic smoothed_present;
	} pbr_flags_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic open;       // take input beats
		logic bound1;     // first bounds stage
		logic bound2;     // second bounds stage, rewind point index
		logic rd;         // read stored point
		logic prep;       // build operands from read data
		logic div_start;  // launch the multiply-divide unit
		logic emit;       // load output register
		logic next;       // advance point index
		logic clear;      // drop path state
	} pbr_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last_beat;  // tlast on a valid input beat
		logic idx_last;   // current point is the final one
		logic bypass;     // current point needs no division
		logic div_busy;   // multiply-divide unit working
		logic out_free;   // output register can take a beat
	} pbr_sts_t;

	// Saturate a 36-bit signed value to the coordinate range
	function automatic logic signed [VW-1:0] sat36(input logic signed [35:0] v);
		logic signed [35:0] vmax;
		logic signed [35:0] vmin;
		vmax = 36'sd2147483647;
		vmin = -36'sd2147483648;
		if (v > vmax) begin
			sat36 = VW'(vmax);
		end else if (v < vmin) begin
			sat36 = VW'(vmin);
		end else begin
			sat36 = VW'(v);
		end
	endfunction

endpackage

### src/pbr_muldiv.sv
// Iterative unsigned a*b/d unit, one multiplier bit per cycle, truncating.
module pbr_muldiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pbr_pkg::AW_MD-1:0]      a,
	input  logic [pbr_pkg::BW_MD-1:0]      b,
	input  logic [pbr_pkg::AW_MD-1:0]      d,
	output logic                           busy,
	output logic [pbr_pkg::BW_MD-1:0]      q
);
	import pbr_pkg::*;

	localparam int CNTW = $clog2(BW_MD + 1);

	logic [AW_MD-1:0] a_q;
	logic [AW_MD-1:0] d_q;
	logic [AW_MD-1:0] rem_q;
	logic [BW_MD-1:0] b_q;
	logic [BW_MD-1:0] q_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;

	logic [AW_MD+1:0] t;
	logic [AW_MD+1:0] d1;
	logic [AW_MD+1:0] d2;
	logic [AW_MD+1:0] t_next;
	logic [1:0]       digit;

	// Shift in one product bit, then take off up to two divisors
	always_comb begin
		d1 = (AW_MD + 2)'(d_q);
		d2 = (AW_MD + 2)'({d_q, 1'b0});
		t = (AW_MD + 2)'({rem_q, 1'b0}) + (b_q[BW_MD-1] ? (AW_MD + 2)'(a_q) : '0);
		if (t >= d2) begin
			t_next = t - d2;
			digit = 2'd2;
		end else if (t >= d1) begin
			t_next = t - d1;
			digit = 2'd1;
		end else begin
			t_next = t;
			digit = 2'd0;
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNTW'(BW_MD);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			d_q <= d;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[BW_MD-2:0], 1'b0};
			rem_q <= AW_MD'(t_next);
			q_q <= {q_q[BW_MD-2:0], 1'b0} + BW_MD'(digit);
		end
	end

	assign busy = busy_q;
	assign q = q_q;

endmodule

### src/pbr_datapath.sv
// Point stores, running bounds, target bounds and result path.
module pbr_datapath #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbr_pkg::pbr_cmd_t             cmd,
	output pbr_pkg::pbr_sts_t             sts,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pbr_pkg::IN_TW-1:0]     s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pbr_pkg::OUT_TW-1:0]    m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	input  logic [1:0]                    cfg_index,
	input  logic [pbr_pkg::VW-1:0]        cfg_data
);
	import pbr_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	// Configuration
	logic signed [VW-1:0] src_min_q;
	logic signed [VW-1:0] src_max_q;
	logic [TW-1:0]        tol_q;

	// Stores
	logic signed [VW-1:0] sv_mem [MAX_POINTS];
	logic signed [VW-1:0] rv_mem [MAX_POINTS];
	pbr_flags_t           fl_mem [MAX_POINTS];

	// Path state
	logic [CW-1:0]        count_q;
	logic signed [VW-1:0] rmin_q;
	logic signed [VW-1:0] rmax_q;
	logic                 seen_q;

	// Bounds stages
	logic signed [VW:0]   span_s1;
	logic signed [VW:0]   sspan_s1;
	logic signed [VW+1:0] tmin_s1;
	logic signed [VW+1:0] tmax_s1;
	logic signed [VW+1:0] minspan_s1;
	logic signed [VW+1:0] tmin_q;
	logic [BW_MD-1:0]     tspan_q;

	// Per-point registers
	logic [AW-1:0]        idx_q;
	logic signed [VW-1:0] rd_sv_q;
	logic signed [VW-1:0] rd_rv_q;
	pbr_flags_t           rd_fl_q;
	logic signed [VW-1:0] byp_val_q;
	logic                 byp_q;

	// Output register
	logic                 out_valid_q;
	logic [VW-1:0]        out_val_q;
	logic [IDXW-1:0]      out_idx_q;
	logic                 out_last_q;

	// Input beat fields
	logic signed [VW-1:0] in_sv;
	logic signed [VW-1:0] in_rv;
	pbr_flags_t           in_fl;
	logic                 in_acc;
	logic signed [VW-1:0] in_v;

	assign in_sv = s_tdata[VW-1:0];
	assign in_fl.smoothed_present = s_tdata[VW];
	assign in_rv = s_tdata[2*VW:VW+1];
	assign in_fl.raw_present = s_tdata[2*VW+1];
	assign in_fl.locked = s_tdata[2*VW+2];
	assign in_acc = s_tvalid && cmd.open;
	assign in_v = in_fl.smoothed_present ? in_sv : '0;
	assign s_tready = cmd.open;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_min_q <= '0;
			src_max_q <= '0;
			tol_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SOURCE_MIN: src_min_q <= cfg_data;
				REG_SOURCE_MAX: src_max_q <= cfg_data;
				REG_TOLERANCE:  tol_q <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// Store writes and store reads
	always_ff @(posedge clk) begin
		if (in_acc && (count_q < CW'(MAX_POINTS))) begin
			sv_mem[count_q[AW-1:0]] <= in_sv;
			rv_mem[count_q[AW-1:0]] <= in_rv;
			fl_mem[count_q[AW-1:0]] <= in_fl;
		end
		if (cmd.rd) begin
			rd_sv_q <= sv_mem[idx_q];
			rd_rv_q <= rv_mem[idx_q];
			rd_fl_q <= fl_mem[idx_q];
		end
	end

	// Track count and running bounds of unlocked points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rmin_q <= {1'b0, {(VW-1){1'b1}}};
			rmax_q <= {1'b1, {(VW-1){1'b0}}};
			seen_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			rmin_q <= {1'b0, {(VW-1){1'b1}}};
			rmax_q <= {1'b1, {(VW-1){1'b0}}};
			seen_q <= 1'b0;
		end else if (in_acc && (count_q < CW'(MAX_POINTS))) begin
			count_q <= count_q + 1'b1;
			if (!in_fl.locked) begin
				seen_q <= 1'b1;
				if (in_v < rmin_q) begin
					rmin_q <= in_v;
				end
				if (in_v > rmax_q) begin
					rmax_q <= in_v;
				end
			end
		end
	end

	// Bounds stage one: spans and clamped sides
	logic signed [VW:0]   b1_span;
	logic signed [VW+1:0] b1_tol;
	logic signed [VW+1:0] b1_lo_min;
	logic signed [VW+1:0] b1_hi_min;
	logic signed [VW+1:0] b1_lo_max;
	logic signed [VW+1:0] b1_hi_max;
	logic signed [VW+1:0] b1_rmin;
	logic signed [VW+1:0] b1_rmax;
	logic signed [VW+1:0] b1_tmin;
	logic signed [VW+1:0] b1_tmax;
	logic signed [VW+1:0] b1_minspan;

	always_comb begin
		b1_span = (VW + 1)'(src_max_q) - (VW + 1)'(src_min_q);
		if (b1_span < 0) begin
			b1_span = '0;
		end
		b1_tol = (VW + 2)'(signed'({1'b0, tol_q}));
		b1_lo_min = (VW + 2)'(src_min_q) - b1_tol;
		b1_hi_min = (VW + 2)'(src_min_q) + b1_tol;
		b1_lo_max = (VW + 2)'(src_max_q) - b1_tol;
		b1_hi_max = (VW + 2)'(src_max_q) + b1_tol;
		b1_rmin = (VW + 2)'(rmin_q);
		b1_rmax = (VW + 2)'(rmax_q);
		if (tol_q == '0) begin
			b1_tmin = (VW + 2)'(src_min_q);
			b1_tmax = (VW + 2)'(src_max_q);
		end else begin
			b1_tmin = (b1_rmin < b1_lo_min) ? b1_lo_min :
				((b1_rmin > b1_hi_min) ? b1_hi_min : b1_rmin);
			b1_tmax = (b1_rmax < b1_lo_max) ? b1_lo_max :
				((b1_rmax > b1_hi_max) ? b1_hi_max : b1_rmax);
		end
		b1_minspan = (VW + 2)'(b1_span) - (b1_tol <<< 1);
		if (b1_minspan < 0) begin
			b1_minspan = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bound1) begin
			span_s1 <= b1_span;
			sspan_s1 <= (VW + 1)'(rmax_q) - (VW + 1)'(rmin_q);
			tmin_s1 <= b1_tmin;
			tmax_s1 <= b1_tmax;
			minspan_s1 <= b1_minspan;
		end
	end

	// Bounds stage two: widen or collapse a narrow span
	logic signed [VW+3:0] b2_diff;
	logic signed [VW+3:0] b2_tol2;
	logic signed [VW:0]   b2_sum;
	logic signed [VW:0]   b2_center;
	logic signed [VW+1:0] b2_tmin;
	logic signed [VW+1:0] b2_tmax;
	logic signed [VW+3:0] b2_tspan;

	always_comb begin
		b2_diff = (VW + 4)'(tmax_s1) - (VW + 4)'(tmin_s1);
		b2_tol2 = (VW + 4)'(signed'({1'b0, tol_q, 1'b0}));
		b2_sum = (VW + 1)'(src_min_q) + (VW + 1)'(src_max_q);
		b2_center = (b2_sum + (VW + 1)'(signed'({1'b0, b2_sum[VW]}))) >>> 1;
		b2_tmin = tmin_s1;
		b2_tmax = tmax_s1;
		if (b2_diff < (VW + 4)'(minspan_s1)) begin
			if ((VW + 4)'(span_s1) > b2_tol2) begin
				b2_tmin = (VW + 2)'(src_min_q) + (VW + 2)'(signed'({1'b0, tol_q}));
				b2_tmax = (VW + 2)'(src_max_q) - (VW + 2)'(signed'({1'b0, tol_q}));
			end else begin
				b2_tmin = (VW + 2)'(b2_center);
				b2_tmax = (VW + 2)'(b2_center);
			end
		end
		b2_tspan = (VW + 4)'(b2_tmax) - (VW + 4)'(b2_tmin);
	end

	always_ff @(posedge clk) begin
		if (cmd.bound2) begin
			tmin_q <= b2_tmin;
			tspan_q <= b2_tspan[BW_MD-1:0];
		end
	end

	// Point index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.bound2) begin
			idx_q <= '0;
		end else if (cmd.next) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Operands for the current point
	logic                 pp_move;
	logic                 pp_flat;
	logic signed [VW-1:0] pp_raw;
	logic signed [VW:0]   pp_num;
	logic signed [VW:0]   pp_dlt;
	logic [AW_MD-1:0]     pp_a;
	logic [AW_MD-1:0]     pp_d;
	logic                 pp_bypass;
	logic signed [VW-1:0] pp_byp_val;

	always_comb begin
		pp_move = seen_q && rd_fl_q.smoothed_present && !rd_fl_q.locked;
		pp_flat = (sspan_s1 <= 0);
		pp_raw = rd_fl_q.raw_present ? rd_rv_q : src_min_q;
		pp_num = (VW + 1)'(pp_raw) - (VW + 1)'(src_min_q);
		if (pp_num < 0) begin
			pp_num = '0;
		end
		if (pp_num > span_s1) begin
			pp_num = span_s1;
		end
		pp_dlt = (VW + 1)'(rd_sv_q) - (VW + 1)'(rmin_q);
		pp_a = pp_flat ? AW_MD'(pp_num) : AW_MD'(pp_dlt);
		pp_d = pp_flat ? AW_MD'(span_s1) : AW_MD'(sspan_s1);
		pp_bypass = !pp_move || (pp_flat && (span_s1 == '0));
		pp_byp_val = pp_move ? sat36(36'(tmin_q)) : rd_sv_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			byp_q <= pp_bypass;
			byp_val_q <= pp_byp_val;
		end
	end

	// Multiply-divide unit
	logic                 md_busy;
	logic [BW_MD-1:0]     md_q;

	pbr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.a      (pp_a),
		.b      (tspan_q),
		.d      (pp_d),
		.busy   (md_busy),
		.q      (md_q)
	);

	// Result and output register
	logic signed [35:0]   res_sum;
	logic signed [VW-1:0] res_val;

	assign res_sum = 36'(tmin_q) + 36'(signed'({1'b0, md_q}));
	assign res_val = byp_q ? byp_val_q : sat36(res_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_val_q <= res_val;
			out_idx_q <= IDXW'(idx_q);
			out_last_q <= sts.idx_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(OUT_TW - VW - IDXW){1'b0}}, out_idx_q, out_val_q};
	assign m_tlast = out_last_q;

	// Status
	assign sts.last_beat = s_tvalid && s_tlast;
	assign sts.idx_last = ((CW'(idx_q) + 1'b1) == count_q);
	assign sts.bypass = pp_bypass;
	assign sts.div_busy = md_busy;
	assign sts.out_free = !out_valid_q || m_tready;

	// Checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("output register overwritten");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !md_busy)
		else $error("divider restarted while busy");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (CW'(idx_q) < count_q))
		else $error("read past loaded points");

endmodule

### src/pbr_ctrl.sv
// Controller state machine: load, bounds, per-point read, prepare, divide unless bypassed, and emit.
module pbr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  pbr_pkg::pbr_sts_t   sts,
	output pbr_pkg::pbr_cmd_t   cmd
);
	import pbr_pkg::*;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_BND1 = 3'd1;
	localparam logic [2:0] ST_BND2 = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_PREP = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_LOAD: begin
				cmd.open = 1'b1;
				if (sts.last_beat) begin
					state_d = ST_BND1;
				end
			end
			ST_BND1: begin
				cmd.bound1 = 1'b1;
				state_d = ST_BND2;
			end
			ST_BND2: begin
				cmd.bound2 = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.bypass) begin
					state_d = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.idx_last) begin
						cmd.clear = 1'b1;
						state_d = ST_LOAD;
					end else begin
						cmd.next = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Checks
	a_last_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && sts.out_free && sts.idx_last) |=> state_q == ST_LOAD)
		else $error("final point did not return to load");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV && sts.div_busy))
		else $error("divider not running after start");
	a_emit_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == ST_EMIT)
		else $error("emit outside emit state");

endmodule

### src/path_bounds_rescale_core.sv
// Top level of the path bounds rescale core.
// Loading takes one point beat per cycle; the beat with tlast starts processing.
// Bounds run in stages bound1 and bound2, then each point is read and prepared;
// it passes unchanged or is rescaled by the 34-step multiply-divide unit.
// The output register frees the datapath as soon as a beat is taken downstream.
// Reset (arst_n low) zeroes control and config, empties the path; stores undefined.
module path_bounds_rescale_core #(
	parameter int MAX_POINTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// tdata: smoothed_value[31:0], smoothed_present[32], raw_coord[64:33],
	//        raw_present[65], locked[66], zero fill[71:67]; tlast: last_point
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pbr_pkg::IN_TW-1:0]   s_tdata,
	input  logic                        s_tlast,
	// tdata: result_value[31:0], point_index[37:32], zero fill[39:38];
	//        tlast: last_result
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pbr_pkg::OUT_TW-1:0]  m_tdata,
	output logic                        m_tlast,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [pbr_pkg::VW-1:0]      cfg_data
);
	import pbr_pkg::*;

	pbr_cmd_t cmd;
	pbr_sts_t sts;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	pbr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pbr_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
